// ----- rtl/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and codes of the bounded deque with search
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int CMD_W         = 3;
	localparam int STATUS_W      = 2;
	localparam int FOUND_W       = 4;
	localparam int OCC_W         = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_LEFT,
		SH_RIGHT
	} shift_t;

endpackage

// ----- rtl/bounded_deque_with_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue of signed words with search from the front
// ----------------------------------------------------------------------------
// entries live in a chain of DEPTH cells with the front in cell 0. push front
// and pop front shift the whole chain by one and finish without a rotation, as
// do a push onto a full queue, a pop from an empty queue, a search of an empty
// queue and unused command codes. push back, pop back and search rotate the
// chain once around through cell 0; the block works on one request at a time.
// no clearing pass after reset.
module bounded_deque_with_search #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic        [bdq_pkg::CMD_W-1:0]   command,
	input  logic signed [bdq_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [bdq_pkg::STATUS_W-1:0] status,
	output logic signed [bdq_pkg::DATA_W-1:0]  result_value,
	output logic        [bdq_pkg::FOUND_W-1:0] found_index,
	output logic        [bdq_pkg::OCC_W-1:0]   occupancy
);

	localparam int IDXW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                          state_q;
	logic [CNTW-1:0]               count_q;
	logic [IDXW-1:0]               step_q;
	logic [bdq_pkg::CMD_W-1:0]     cmd_q;
	bdq_pkg::data_t                key_q;
	logic                          hit_q;
	logic [IDXW-1:0]               idx_q;
	bdq_pkg::data_t                rval_q;

	logic                          out_valid_q;
	logic [bdq_pkg::STATUS_W-1:0]  status_q;
	bdq_pkg::data_t                result_q;
	logic [IDXW-1:0]               found_q;
	logic [CNTW-1:0]               occ_q;

	bdq_pkg::shift_t               shift;
	bdq_pkg::data_t                head;
	bdq_pkg::data_t                tail_in;

	logic                          accept;
	logic                          is_full;
	logic                          is_empty;
	logic                          needs_scan;
	logic                          last_step;
	logic [CNTW-1:0]               step_ext;
	logic                          match_now;
	logic                          back_now;
	logic                          load_out;
	logic [bdq_pkg::STATUS_W-1:0]  res_status;
	bdq_pkg::data_t                res_value;
	logic [IDXW-1:0]               res_index;
	logic [CNTW-1:0]               res_count;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_full   = count_q == CNTW'(DEPTH);
	assign is_empty  = count_q == '0;
	assign last_step = step_q == IDXW'(DEPTH - 1);
	assign step_ext  = CNTW'(step_q);
	assign match_now = !hit_q && (step_ext < count_q) && (head == key_q);
	assign back_now  = step_ext == (count_q - CNTW'(1));

	assign needs_scan = ((command == bdq_pkg::CMD_PUSH_BACK) && !is_full)
		|| ((command == bdq_pkg::CMD_POP_BACK) && !is_empty)
		|| ((command == bdq_pkg::CMD_SEARCH) && !is_empty);

	assign tail_in = ((state_q == S_SCAN) && (cmd_q == bdq_pkg::CMD_PUSH_BACK)
		&& (step_ext == count_q)) ? key_q : head;

	always_comb begin
		shift = bdq_pkg::SH_HOLD;
		if (state_q == S_SCAN) begin
			shift = bdq_pkg::SH_LEFT;
		end else if (accept && !needs_scan) begin
			if ((command == bdq_pkg::CMD_PUSH_FRONT) && !is_full) begin
				shift = bdq_pkg::SH_RIGHT;
			end else if ((command == bdq_pkg::CMD_POP_FRONT) && !is_empty) begin
				shift = bdq_pkg::SH_LEFT;
			end
		end
	end

	// result of a request that needs no rotation, or of a rotation on its last step
	always_comb begin
		load_out   = 1'b0;
		res_status = bdq_pkg::ST_OK;
		res_value  = '0;
		res_index  = '0;
		res_count  = count_q;
		if (state_q == S_SCAN) begin
			load_out = last_step;
			unique case (cmd_q)
				bdq_pkg::CMD_PUSH_BACK: begin
					res_value = key_q;
					res_count = count_q + CNTW'(1);
				end
				bdq_pkg::CMD_POP_BACK: begin
					res_value = back_now ? head : rval_q;
					res_count = count_q - CNTW'(1);
				end
				default: begin
					res_value = key_q;
					if (hit_q) begin
						res_index = idx_q;
					end else if (match_now) begin
						res_index = step_q;
					end else begin
						res_status = bdq_pkg::ST_NOT_FOUND;
					end
				end
			endcase
		end else if (accept && !needs_scan) begin
			load_out = 1'b1;
			unique case (command)
				bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
					res_value = value;
					if (is_full) begin
						res_status = bdq_pkg::ST_FULL;
					end else begin
						res_count = count_q + CNTW'(1);
					end
				end
				bdq_pkg::CMD_POP_FRONT: begin
					if (is_empty) begin
						res_status = bdq_pkg::ST_EMPTY;
					end else begin
						res_value = head;
						res_count = count_q - CNTW'(1);
					end
				end
				bdq_pkg::CMD_POP_BACK: begin
					res_status = bdq_pkg::ST_EMPTY;
				end
				bdq_pkg::CMD_SEARCH: begin
					res_value  = value;
					res_status = bdq_pkg::ST_NOT_FOUND;
				end
				default: begin
					res_value = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				count_q     <= res_count;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && needs_scan) begin
						state_q <= S_SCAN;
						step_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				default: begin
					step_q <= step_q + IDXW'(1);
					if (match_now && (cmd_q == bdq_pkg::CMD_SEARCH)) begin
						hit_q <= 1'b1;
					end
					if (last_step) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// request payload and scan capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			key_q <= value;
		end
		if (state_q == S_SCAN) begin
			if (match_now && (cmd_q == bdq_pkg::CMD_SEARCH)) begin
				idx_q <= step_q;
			end
			if (back_now) begin
				rval_q <= head;
			end
		end
		if (load_out) begin
			status_q <= res_status;
			result_q <= res_value;
			found_q  <= res_index;
			occ_q    <= res_count;
		end
	end

	bdq_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk     (clk),
		.shift   (shift),
		.head_in (value),
		.tail_in (tail_in),
		.head    (head)
	);

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign found_index  = bdq_pkg::FOUND_W'(found_q);
	assign occupancy    = bdq_pkg::OCC_W'(occ_q);

endmodule

// ----- rtl/bdq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// one storage cell of the chain, loads from either neighbor or holds
// ----------------------------------------------------------------------------
module bdq_cell (
	input  logic            clk,
	input  bdq_pkg::shift_t shift,
	input  bdq_pkg::data_t  from_left,
	input  bdq_pkg::data_t  from_right,
	output bdq_pkg::data_t  data
);

	bdq_pkg::data_t data_q;

	always_ff @(posedge clk) begin
		unique case (shift)
			bdq_pkg::SH_LEFT: begin
				data_q <= from_right;
			end
			bdq_pkg::SH_RIGHT: begin
				data_q <= from_left;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ----- rtl/bdq_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_chain
// row of cells; cell 0 holds the front, shifts left or right as one
// ----------------------------------------------------------------------------
module bdq_chain #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  bdq_pkg::shift_t shift,
	input  bdq_pkg::data_t  head_in,
	input  bdq_pkg::data_t  tail_in,
	output bdq_pkg::data_t  head
);

	bdq_pkg::data_t cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdq_pkg::data_t left_nb;
		bdq_pkg::data_t right_nb;

		if (i == 0) begin : g_first
			assign left_nb = head_in;
		end else begin : g_mid_l
			assign left_nb = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_nb = tail_in;
		end else begin : g_mid_r
			assign right_nb = cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_left  (left_nb),
			.from_right (right_nb),
			.data       (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule
